[hdl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check with the reset masked out.
`define SWFT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sliding window stats check failed");

// Concurrent check that also holds while reset is applied.
`define SWFT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("sliding window stats check failed");

`endif

[hdl/swft_pkg.sv]
package swft_pkg;

   localparam int WINDOW_DEPTH = 1024;
   localparam int ADDR_BITS    = $clog2(WINDOW_DEPTH);
   localparam int COUNT_BITS   = ADDR_BITS + 1;
   localparam int DELTA_BITS   = 20;
   localparam int LIMIT_BITS   = 30;
   localparam int TOTAL_BITS   = LIMIT_BITS + 1;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 30'd5000000;

   // count / 100 as a multiply by a scaled reciprocal; exact for counts up to 1024.
   localparam int PCT_MULT  = 5243;
   localparam int PCT_SHIFT = 19;
   localparam int PCT_PROD  = COUNT_BITS + 13;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_EVICT_TAKE,
      DP_SRT_RD_IDX,
      DP_IDX_INC,
      DP_SRT_RD_NEXT,
      DP_SHIFT_WR,
      DP_EVICT_DONE,
      DP_INS_START,
      DP_SRT_RD_PREV,
      DP_INS_MOVE,
      DP_INS_PUT,
      DP_RD_HEAD,
      DP_RD_PCT,
      DP_CAP_LOW,
      DP_RSP_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic match;
      logic shift_more;
      logic idx_zero;
      logic ins_less;
      logic over_limit;
      logic rsp_free;
   } dp_status_type;

   function automatic logic [ADDR_BITS-1:0] pct_index(input logic [COUNT_BITS-1:0] count);
      logic [PCT_PROD-1:0] prod;
      prod = PCT_PROD'(count) * PCT_PROD'(PCT_MULT);
      return ADDR_BITS'(prod >> PCT_SHIFT);
   endfunction

endpackage

[hdl/swft_datapath.sv]
module swft_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  swft_pkg::dp_cmd_type                cmd,
   output swft_pkg::dp_status_type             status,
   input  logic [swft_pkg::DELTA_BITS-1:0]     req_delta_us,
   input  logic                                csr_write_enable,
   input  logic [swft_pkg::LIMIT_BITS-1:0]     csr_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [swft_pkg::DELTA_BITS-1:0]     rsp_worst_delta,
   output logic [swft_pkg::DELTA_BITS-1:0]     rsp_low_pct_delta,
   output logic [swft_pkg::LIMIT_BITS-1:0]     rsp_window_total,
   output logic [swft_pkg::COUNT_BITS-1:0]     rsp_window_count,
   output logic                                rsp_depth_overflow
);

   logic [swft_pkg::DELTA_BITS-1:0] ring_mem [swft_pkg::WINDOW_DEPTH];
   logic [swft_pkg::DELTA_BITS-1:0] srt_mem  [swft_pkg::WINDOW_DEPTH];

   logic [swft_pkg::LIMIT_BITS-1:0] limit_ff;
   logic [swft_pkg::ADDR_BITS-1:0]  head_ff;
   logic [swft_pkg::COUNT_BITS-1:0] count_ff;
   logic [swft_pkg::TOTAL_BITS-1:0] total_ff;
   logic [swft_pkg::COUNT_BITS-1:0] idx_ff;
   logic [swft_pkg::DELTA_BITS-1:0] new_ff;
   logic [swft_pkg::DELTA_BITS-1:0] old_ff;
   logic                            ovf_ff;
   logic [swft_pkg::DELTA_BITS-1:0] ring_rd_ff;
   logic [swft_pkg::DELTA_BITS-1:0] srt_rd_ff;
   logic [swft_pkg::DELTA_BITS-1:0] worst_ff;
   logic [swft_pkg::DELTA_BITS-1:0] low_ff;
   logic                            rsp_valid_ff;
   logic [swft_pkg::DELTA_BITS-1:0] rsp_worst_ff;
   logic [swft_pkg::DELTA_BITS-1:0] rsp_low_ff;
   logic [swft_pkg::LIMIT_BITS-1:0] rsp_total_ff;
   logic [swft_pkg::COUNT_BITS-1:0] rsp_count_ff;
   logic                            rsp_ovf_ff;

   logic [swft_pkg::ADDR_BITS-1:0]  srt_ra;
   logic                            srt_we;
   logic [swft_pkg::DELTA_BITS-1:0] srt_wd;
   logic [swft_pkg::COUNT_BITS-1:0] idx_next;
   logic [swft_pkg::COUNT_BITS-1:0] idx_prev;
   logic [swft_pkg::ADDR_BITS-1:0]  ring_wa;

   assign idx_next = idx_ff + swft_pkg::COUNT_BITS'(1);
   assign idx_prev = idx_ff - swft_pkg::COUNT_BITS'(1);
   assign ring_wa  = head_ff + count_ff[swft_pkg::ADDR_BITS-1:0];

   // Read address and write port of the sorted store follow the command.
   always_comb begin
      srt_ra = idx_ff[swft_pkg::ADDR_BITS-1:0];
      srt_we = 1'b0;
      srt_wd = srt_rd_ff;
      unique case (cmd.op)
         swft_pkg::DP_SRT_RD_NEXT: srt_ra = idx_next[swft_pkg::ADDR_BITS-1:0];
         swft_pkg::DP_SRT_RD_PREV: srt_ra = idx_prev[swft_pkg::ADDR_BITS-1:0];
         swft_pkg::DP_RD_HEAD:     srt_ra = '0;
         swft_pkg::DP_RD_PCT:      srt_ra = swft_pkg::pct_index(count_ff);
         swft_pkg::DP_SHIFT_WR,
         swft_pkg::DP_INS_MOVE:    srt_we = 1'b1;
         swft_pkg::DP_INS_PUT: begin
            srt_we = 1'b1;
            srt_wd = new_ff;
         end
         default: srt_ra = idx_ff[swft_pkg::ADDR_BITS-1:0];
      endcase
   end

   // Arrival ring: written at the tail, always read at the head.
   always_ff @(posedge clock) begin
      if (cmd.op == swft_pkg::DP_INS_START) begin
         ring_mem[ring_wa] <= new_ff;
      end
      ring_rd_ff <= ring_mem[head_ff];
   end

   // Sorted store, one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (srt_we) begin
         srt_mem[idx_ff[swft_pkg::ADDR_BITS-1:0]] <= srt_wd;
      end
      srt_rd_ff <= srt_mem[srt_ra];
   end

   // Window state and per-item working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= swft_pkg::LIMIT_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         if (cmd.op == swft_pkg::DP_RSP_LOAD) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd.op)
            swft_pkg::DP_LOAD: begin
               new_ff <= req_delta_us;
               ovf_ff <= status.full;
            end
            swft_pkg::DP_EVICT_TAKE: begin
               old_ff   <= ring_rd_ff;
               idx_ff   <= '0;
               total_ff <= (total_ff >= swft_pkg::TOTAL_BITS'(ring_rd_ff)) ?
                           total_ff - swft_pkg::TOTAL_BITS'(ring_rd_ff) : '0;
            end
            swft_pkg::DP_IDX_INC,
            swft_pkg::DP_SHIFT_WR:  idx_ff <= idx_next;
            swft_pkg::DP_INS_MOVE:  idx_ff <= idx_prev;
            swft_pkg::DP_EVICT_DONE: begin
               count_ff <= count_ff - swft_pkg::COUNT_BITS'(1);
               head_ff  <= head_ff + swft_pkg::ADDR_BITS'(1);
            end
            swft_pkg::DP_INS_START: begin
               idx_ff   <= count_ff;
               total_ff <= total_ff + swft_pkg::TOTAL_BITS'(new_ff);
            end
            swft_pkg::DP_INS_PUT:   count_ff <= count_ff + swft_pkg::COUNT_BITS'(1);
            swft_pkg::DP_RD_PCT:    worst_ff <= srt_rd_ff;
            swft_pkg::DP_CAP_LOW:   low_ff   <= srt_rd_ff;
            swft_pkg::DP_RSP_LOAD: begin
               rsp_worst_ff <= worst_ff;
               rsp_low_ff   <= low_ff;
               rsp_total_ff <= total_ff[swft_pkg::LIMIT_BITS-1:0];
               rsp_count_ff <= count_ff;
               rsp_ovf_ff   <= ovf_ff;
            end
            default: begin
               idx_ff <= idx_ff;
            end
         endcase
      end
   end

   // Status back to the controller.
   always_comb begin
      status.full       = (count_ff == swft_pkg::COUNT_BITS'(swft_pkg::WINDOW_DEPTH));
      status.match      = (srt_rd_ff == old_ff);
      status.shift_more = (idx_next < count_ff);
      status.idx_zero   = (idx_ff == '0);
      status.ins_less   = (srt_rd_ff < new_ff);
      status.over_limit = (total_ff > swft_pkg::TOTAL_BITS'(limit_ff)) &&
                          (count_ff > swft_pkg::COUNT_BITS'(1));
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_worst_delta    = rsp_worst_ff;
   assign rsp_low_pct_delta  = rsp_low_ff;
   assign rsp_window_total   = rsp_total_ff;
   assign rsp_window_count   = rsp_count_ff;
   assign rsp_depth_overflow = rsp_ovf_ff;

endmodule

[hdl/swft_controller.sv]
module swft_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  swft_pkg::dp_status_type status,
   output swft_pkg::dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_E_RD,
      ST_E_TAKE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SH_RD,
      ST_SH_WR,
      ST_I_START,
      ST_I_RD,
      ST_I_CHK,
      ST_L_CHK,
      ST_O_RD0,
      ST_O_RD1,
      ST_O_CAP,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      ret_ins_ff, ret_ins_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and datapath command.
   always_comb begin
      state_in   = state_ff;
      ret_ins_in = ret_ins_ff;
      cmd.op     = swft_pkg::DP_NOP;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op     = swft_pkg::DP_LOAD;
               ret_ins_in = status.full;
               state_in   = status.full ? ST_E_RD : ST_I_START;
            end
         end
         ST_E_RD:   state_in = ST_E_TAKE;
         ST_E_TAKE: begin
            cmd.op   = swft_pkg::DP_EVICT_TAKE;
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            cmd.op   = swft_pkg::DP_SRT_RD_IDX;
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (status.match) begin
               state_in = ST_SH_RD;
            end else begin
               cmd.op   = swft_pkg::DP_IDX_INC;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SH_RD: begin
            if (status.shift_more) begin
               cmd.op   = swft_pkg::DP_SRT_RD_NEXT;
               state_in = ST_SH_WR;
            end else begin
               cmd.op   = swft_pkg::DP_EVICT_DONE;
               state_in = ret_ins_ff ? ST_I_START : ST_L_CHK;
            end
         end
         ST_SH_WR: begin
            cmd.op   = swft_pkg::DP_SHIFT_WR;
            state_in = ST_SH_RD;
         end
         ST_I_START: begin
            cmd.op   = swft_pkg::DP_INS_START;
            state_in = ST_I_RD;
         end
         ST_I_RD: begin
            if (status.idx_zero) begin
               cmd.op   = swft_pkg::DP_INS_PUT;
               state_in = ST_L_CHK;
            end else begin
               cmd.op   = swft_pkg::DP_SRT_RD_PREV;
               state_in = ST_I_CHK;
            end
         end
         ST_I_CHK: begin
            if (status.ins_less) begin
               cmd.op   = swft_pkg::DP_INS_MOVE;
               state_in = ST_I_RD;
            end else begin
               cmd.op   = swft_pkg::DP_INS_PUT;
               state_in = ST_L_CHK;
            end
         end
         ST_L_CHK: begin
            ret_ins_in = 1'b0;
            state_in   = status.over_limit ? ST_E_RD : ST_O_RD0;
         end
         ST_O_RD0: begin
            cmd.op   = swft_pkg::DP_RD_HEAD;
            state_in = ST_O_RD1;
         end
         ST_O_RD1: begin
            cmd.op   = swft_pkg::DP_RD_PCT;
            state_in = ST_O_CAP;
         end
         ST_O_CAP: begin
            cmd.op   = swft_pkg::DP_CAP_LOW;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (status.rsp_free) begin
               cmd.op   = swft_pkg::DP_RSP_LOAD;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ret_ins_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ret_ins_ff <= ret_ins_in;
      end
   end

endmodule

[hdl/sliding_window_frame_time_stats.sv]
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  req_delta_us
// rsp      out        rsp_valid/rsp_ready  worst, low_pct, total, count, overflow
// csr      in         csr_write_enable     csr_write_data (window total limit)
//
// An insert moves each sorted entry smaller than the new frame down one place; each
// eviction scans past the entries ahead of the oldest frame and shifts the ones after
// it up. Evictions come from a full window or a total over the limit. The single sorted
// store port sets the pace; a new item is taken only after the last result is loaded.
// Reset is synchronous and restores the limit to 5000000 with an empty window.
// A stalled result holds the last step of the following item.
module sliding_window_frame_time_stats (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [swft_pkg::DELTA_BITS-1:0] req_delta_us,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [swft_pkg::DELTA_BITS-1:0] rsp_worst_delta,
   output logic [swft_pkg::DELTA_BITS-1:0] rsp_low_pct_delta,
   output logic [swft_pkg::LIMIT_BITS-1:0] rsp_window_total,
   output logic [swft_pkg::COUNT_BITS-1:0] rsp_window_count,
   output logic                            rsp_depth_overflow,
   input  logic                            csr_write_enable,
   input  logic [swft_pkg::LIMIT_BITS-1:0] csr_write_data
);

   swft_pkg::dp_cmd_type    cmd;
   swft_pkg::dp_status_type status;

   // Sequencer.
   swft_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Window stores, totals and result register.
   swft_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_delta_us       (req_delta_us),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_worst_delta    (rsp_worst_delta),
      .rsp_low_pct_delta  (rsp_low_pct_delta),
      .rsp_window_total   (rsp_window_total),
      .rsp_window_count   (rsp_window_count),
      .rsp_depth_overflow (rsp_depth_overflow)
   );

endmodule

[hdl/swft_checker.sv]
`include "assert_macros.svh"

module swft_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [swft_pkg::DELTA_BITS-1:0] rsp_worst_delta,
   input logic [swft_pkg::DELTA_BITS-1:0] rsp_low_pct_delta,
   input logic [swft_pkg::COUNT_BITS-1:0] rsp_window_count
);

   // A stalled result keeps its worst delta and window count.
   `SWFT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_worst_delta) && $stable(rsp_window_count))

   // A delivered window is never empty.
   `SWFT_ASSERT(a_count_nonzero, clock, reset, rsp_valid |-> rsp_window_count != '0)

   // The worst frame bounds the low-percentile frame in a descending store.
   `SWFT_ASSERT(a_worst_bound, clock, reset, rsp_valid |-> rsp_worst_delta >= rsp_low_pct_delta)

   // After a transfer in, the block is busy for at least the next cycle.
   `SWFT_ASSERT_ALWAYS(a_busy_after_take, clock, !reset && req_valid && req_ready |=> !req_ready)

endmodule

bind sliding_window_frame_time_stats swft_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_worst_delta   (rsp_worst_delta),
   .rsp_low_pct_delta (rsp_low_pct_delta),
   .rsp_window_count  (rsp_window_count)
);
